@@ design/lic_pkg.sv @@
// Package for the lamp ignition controller.
// Holds the input and result word types and the fixed codes; no dependencies.
package lic_pkg;

  // Width of the configuration data port (widest register).
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IGN_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POST_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAMP_MASK    = 2'd3;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] IGN_TIMEOUT_RST  = 16'd120;
  localparam logic [CFG_W-1:0] POST_TIMEOUT_RST = 16'd60;
  localparam logic [1:0]       LAMP_MASK_RST    = 2'b11;

  // Command codes.
  localparam logic [1:0] CMD_ON  = 2'd1;
  localparam logic [1:0] CMD_OFF = 2'd2;

  // Notification kinds.
  localparam logic MSG_ONOFF = 1'b0;
  localparam logic MSG_ERROR = 1'b1;

  // Error codes.
  localparam logic [1:0] ERR_TIMEOUT = 2'd0;
  localparam logic [1:0] ERR_LAMP    = 2'd1;
  localparam logic [1:0] ERR_SAFETY  = 2'd2;

  // One scheduler pass.
  typedef struct packed {
    logic [1:0] command;
    logic       safety_active;
    logic       left_sensor;
    logic       right_sensor;
    logic       sample_strobe;
    logic       second_tick;
    logic       msg_accepted;
  } in_word_t;

  // Result of one pass.
  typedef struct packed {
    logic       left_drive;
    logic       right_drive;
    logic       msg_valid;
    logic       msg_kind;
    logic       msg_lamps_ok;
    logic [1:0] msg_error_code;
    logic       msg_last_request;
    logic       msg_left_status;
    logic       msg_right_status;
    logic [2:0] ctrl_state;
  } out_word_t;

endpackage

@@ design/lic_debounce.sv @@
// One debounce sample of a lamp sensor: saturating counter with hysteresis.
// Uses no package items.
module lic_debounce #(
  parameter int DEBOUNCE_COUNT = 4
) (
  input  logic                                  en,
  input  logic                                  sense,
  input  logic [$clog2(DEBOUNCE_COUNT+1)-1:0]   cnt,
  input  logic                                  status,
  output logic [$clog2(DEBOUNCE_COUNT+1)-1:0]   cnt_next,
  output logic                                  status_next
);

  localparam int CW = $clog2(DEBOUNCE_COUNT + 1);
  localparam logic [CW-1:0] TOP = CW'(DEBOUNCE_COUNT);

  // Count toward the top on a lit bit, toward zero otherwise.
  always_comb begin
    cnt_next    = cnt;
    status_next = status;
    if (en) begin
      if (sense) begin
        if (cnt < TOP) begin
          cnt_next = cnt + CW'(1);
        end
      end else if (cnt != '0) begin
        cnt_next = cnt - CW'(1);
      end
      // Status only changes at the two ends of the range.
      if (cnt_next == TOP) begin
        status_next = 1'b1;
      end else if (cnt_next == '0) begin
        status_next = 1'b0;
      end
    end
  end

endmodule

@@ design/lamp_ignition_controller_top.sv @@
// Two-lamp ignition controller, top level.
// Depends on lic_pkg and lic_debounce.
//
// Usage: each input word on in_word is one scheduler pass (command, interlock,
// sensor bits, sample strobe, second tick and the acceptance flag for the
// notification offered on the previous result). A word is taken at a clock
// edge where in_valid is high and in_stall is low. Each accepted word yields
// exactly one result word on out_word, shown with out_valid in the cycle after
// acceptance and held until out_stall is low at a clock edge.
// One word can be taken every cycle while out_stall is low: the whole pass
// (two debounce samples, timer updates and the control step) is a single
// level of logic from the held state into the state and result registers.
// While a result waits under out_stall, in_stall is high; as soon as the
// result is taken, a new word is accepted in the same cycle.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data); the user
// must write it only while the block is idle, which the block does not enforce.
// Reset (rst, synchronous) puts the machine in the off state with lamps off,
// clears all counters and timers, and loads the register defaults
// (120 s ignition timeout, 60 s post-ignition, no bypass, both lamps enabled).
module lamp_ignition_controller_top #(
  parameter int DEBOUNCE_COUNT = 4,
  parameter int TIMER_WIDTH    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lic_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lic_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lic_pkg::out_word_t             out_word
);

  localparam int CW = $clog2(DEBOUNCE_COUNT + 1);
  localparam int TW = TIMER_WIDTH;
  localparam logic [63:0] TIMER_MAX = (64'd1 << TW) - 64'd1;

  typedef enum logic [2:0] {
    ST_OFF        = 3'd0,
    ST_IGN        = 3'd1,
    ST_POST       = 3'd2,
    ST_SEND_ONOFF = 3'd3,
    ST_ON         = 3'd4,
    ST_SEND_ERR   = 3'd5,
    ST_SAFE       = 3'd6
  } state_t;

  // Configuration registers.
  logic [lic_pkg::CFG_W-1:0] ign_timeout;
  logic [lic_pkg::CFG_W-1:0] post_timeout;
  logic                      sensor_bypass;
  logic [1:0]                lamp_mask;

  // Controller state. Lamp index 0 is left, 1 is right.
  state_t          state;
  state_t          return_state;
  logic            pending_on;
  logic            pending_off;
  logic            last_request;
  logic            error_reported;
  logic [1:0]      error_code;
  logic [CW-1:0]   debounce_count [2];
  logic [1:0]      lamp_status;
  logic [TW-1:0]   ignition_timer;
  logic [TW-1:0]   post_ignition_timer;
  logic [1:0]      drive;

  // Next values.
  state_t          state_next;
  state_t          return_state_next;
  logic            pending_on_next;
  logic            pending_off_next;
  logic            last_request_next;
  logic            error_reported_next;
  logic [1:0]      error_code_next;
  logic [CW-1:0]   debounce_count_next [2];
  logic [1:0]      lamp_status_next;
  logic [TW-1:0]   ignition_timer_next;
  logic [TW-1:0]   post_ignition_timer_next;
  logic [1:0]      drive_next;
  lic_pkg::out_word_t result_next;

  // Sample results: stage a is the strobe sample, stage b the state sample.
  logic [CW-1:0]   cnt_a [2];
  logic [CW-1:0]   cnt_b [2];
  logic [1:0]      stat_a;
  logic [1:0]      stat_b;
  logic [1:0]      sense;
  logic            ok_a;
  logic            ok_b;
  logic [TW-1:0]   ign_load;
  logic [TW-1:0]   post_load;
  logic            accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // A disabled lamp reads as dark.
  assign sense[0] = lamp_mask[1] & in_word.left_sensor;
  assign sense[1] = lamp_mask[0] & in_word.right_sensor;

  // Debounce filters, two chained samples per lamp.
  for (genvar i = 0; i < 2; i++) begin : g_lamp
    lic_debounce #(
      .DEBOUNCE_COUNT(DEBOUNCE_COUNT)
    ) u_sample_a (
      .en          (in_word.sample_strobe & ~sensor_bypass),
      .sense       (sense[i]),
      .cnt         (debounce_count[i]),
      .status      (lamp_status[i]),
      .cnt_next    (cnt_a[i]),
      .status_next (stat_a[i])
    );
    lic_debounce #(
      .DEBOUNCE_COUNT(DEBOUNCE_COUNT)
    ) u_sample_b (
      .en          (~sensor_bypass),
      .sense       (sense[i]),
      .cnt         (cnt_a[i]),
      .status      (stat_a[i]),
      .cnt_next    (cnt_b[i]),
      .status_next (stat_b[i])
    );
  end

  // Effective left status: on under bypass; borrows the right lamp's when only that one is enabled.
  function automatic logic left_eff(logic bypass, logic [1:0] mask, logic [1:0] stat);
    logic r;
    if (bypass) begin
      r = 1'b1;
    end else if (!mask[1] && mask[0]) begin
      r = stat[1];
    end else begin
      r = stat[0];
    end
    return r;
  endfunction

  // Effective right status: on under bypass; borrows the left lamp's when only that one is enabled.
  function automatic logic right_eff(logic bypass, logic [1:0] mask, logic [1:0] stat);
    logic r;
    if (bypass) begin
      r = 1'b1;
    end else if (!mask[0] && mask[1]) begin
      r = stat[0];
    end else begin
      r = stat[1];
    end
    return r;
  endfunction

  // All enabled lamps report on; true when no lamp is enabled.
  function automatic logic lamps_ok(logic bypass, logic [1:0] mask, logic [1:0] stat);
    logic r;
    r = 1'b1;
    if (mask[1] && !left_eff(bypass, mask, stat)) begin
      r = 1'b0;
    end
    if (mask[0] && !right_eff(bypass, mask, stat)) begin
      r = 1'b0;
    end
    return r;
  endfunction

  // Drive update for enabled lamps only.
  function automatic logic [1:0] drive_set(logic [1:0] mask, logic [1:0] cur, logic on);
    logic [1:0] d;
    d = cur;
    if (mask[1]) begin
      d[0] = on;
    end
    if (mask[0]) begin
      d[1] = on;
    end
    return d;
  endfunction

  assign ok_a = lamps_ok(sensor_bypass, lamp_mask, stat_a);
  assign ok_b = lamps_ok(sensor_bypass, lamp_mask, stat_b);

  // Timer load values, saturated to the timer width.
  always_comb begin
    ign_load  = ({48'd0, ign_timeout} > TIMER_MAX) ? '1 : TW'(ign_timeout);
    post_load = ({48'd0, post_timeout} > TIMER_MAX) ? '1 : TW'(post_timeout);
  end

  // One scheduler pass.
  always_comb begin
    state_next          = state;
    return_state_next   = return_state;
    pending_on_next     = pending_on;
    pending_off_next    = pending_off;
    last_request_next   = last_request;
    error_reported_next = error_reported;
    error_code_next     = error_code;
    debounce_count_next = cnt_a;
    lamp_status_next    = stat_a;
    ignition_timer_next = ignition_timer;
    post_ignition_timer_next = post_ignition_timer;
    drive_next          = drive;
    result_next         = '0;

    // Latch the command.
    if (in_word.command == lic_pkg::CMD_ON) begin
      last_request_next   = 1'b1;
      pending_on_next     = 1'b1;
      pending_off_next    = 1'b0;
      error_reported_next = 1'b0;
    end else if (in_word.command == lic_pkg::CMD_OFF) begin
      last_request_next = 1'b0;
      pending_off_next  = 1'b1;
      pending_on_next   = 1'b0;
    end

    // Second tick, saturating at zero.
    if (in_word.second_tick) begin
      if (ignition_timer != '0) begin
        ignition_timer_next = ignition_timer - TW'(1);
      end
      if (post_ignition_timer != '0) begin
        post_ignition_timer_next = post_ignition_timer - TW'(1);
      end
    end

    // Control step.
    unique case (state)
      ST_OFF: begin
        if (pending_on_next) begin
          pending_on_next = 1'b0;
          if (!in_word.safety_active) begin
            debounce_count_next = '{default: '0};
            drive_next          = drive_set(lamp_mask, drive, 1'b1);
            ignition_timer_next = ign_load;
            state_next          = ST_IGN;
          end else begin
            error_reported_next = 1'b1;
            return_state_next   = ST_SAFE;
            error_code_next     = lic_pkg::ERR_SAFETY;
            state_next          = ST_SEND_ERR;
          end
        end else if (pending_off_next) begin
          pending_off_next    = 1'b0;
          debounce_count_next = '{default: '0};
          drive_next          = drive_set(lamp_mask, drive, 1'b0);
          return_state_next   = ST_OFF;
          state_next          = ST_SEND_ONOFF;
        end
      end
      ST_IGN: begin
        if (pending_off_next) begin
          pending_off_next    = 1'b0;
          debounce_count_next = '{default: '0};
          drive_next          = drive_set(lamp_mask, drive, 1'b0);
          state_next          = ST_SEND_ONOFF;
        end else begin
          debounce_count_next = cnt_b;
          lamp_status_next    = stat_b;
          if (ok_b) begin
            post_ignition_timer_next = post_load;
            state_next               = ST_POST;
          end else if (ignition_timer_next == '0) begin
            debounce_count_next = '{default: '0};
            drive_next          = drive_set(lamp_mask, drive, 1'b0);
            return_state_next   = ST_OFF;
            error_code_next     = lic_pkg::ERR_TIMEOUT;
            state_next          = ST_SEND_ERR;
          end
        end
      end
      ST_POST: begin
        if (pending_off_next) begin
          pending_off_next    = 1'b0;
          debounce_count_next = '{default: '0};
          drive_next          = drive_set(lamp_mask, drive, 1'b0);
          state_next          = ST_SEND_ONOFF;
        end else begin
          debounce_count_next = cnt_b;
          lamp_status_next    = stat_b;
          if (!ok_b) begin
            state_next = ST_IGN;
          end else if (post_ignition_timer_next == '0) begin
            return_state_next = ST_ON;
            state_next        = ST_SEND_ONOFF;
          end
        end
      end
      ST_SEND_ONOFF: begin
        result_next.msg_valid    = 1'b1;
        result_next.msg_kind     = lic_pkg::MSG_ONOFF;
        result_next.msg_lamps_ok = ok_a;
        if (in_word.msg_accepted) begin
          state_next = return_state;
        end
      end
      ST_ON: begin
        if (pending_off_next) begin
          pending_off_next    = 1'b0;
          debounce_count_next = '{default: '0};
          drive_next          = drive_set(lamp_mask, drive, 1'b0);
          return_state_next   = ST_OFF;
          state_next          = ST_SEND_ONOFF;
        end else if (pending_on_next) begin
          pending_on_next   = 1'b0;
          return_state_next = ST_ON;
          state_next        = ST_SEND_ONOFF;
        end else if (!ok_a && !error_reported_next) begin
          error_reported_next = 1'b1;
          if (!in_word.safety_active) begin
            return_state_next = ST_ON;
            error_code_next   = lic_pkg::ERR_LAMP;
          end else begin
            return_state_next = ST_SAFE;
            error_code_next   = lic_pkg::ERR_SAFETY;
          end
          state_next = ST_SEND_ERR;
        end
      end
      ST_SEND_ERR: begin
        result_next.msg_valid        = 1'b1;
        result_next.msg_kind         = lic_pkg::MSG_ERROR;
        result_next.msg_error_code   = error_code;
        result_next.msg_last_request = last_request_next;
        result_next.msg_left_status  = left_eff(sensor_bypass, lamp_mask, stat_a);
        result_next.msg_right_status = right_eff(sensor_bypass, lamp_mask, stat_a);
        if (in_word.msg_accepted) begin
          state_next = return_state;
        end
      end
      ST_SAFE: begin
        if (in_word.safety_active) begin
          if (pending_on_next) begin
            pending_on_next   = 1'b0;
            return_state_next = ST_SAFE;
            error_code_next   = lic_pkg::ERR_SAFETY;
            state_next        = ST_SEND_ERR;
          end else begin
            pending_on_next  = 1'b0;
            pending_off_next = 1'b0;
          end
        end else begin
          pending_on_next     = 1'b0;
          pending_off_next    = 1'b0;
          debounce_count_next = '{default: '0};
          drive_next          = drive_set(lamp_mask, drive, 1'b0);
          state_next          = ST_OFF;
        end
      end
      default: begin
      end
    endcase

    result_next.left_drive  = drive_next[0];
    result_next.right_drive = drive_next[1];
    result_next.ctrl_state  = 3'(state_next);
  end

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ign_timeout         <= lic_pkg::IGN_TIMEOUT_RST;
      post_timeout        <= lic_pkg::POST_TIMEOUT_RST;
      sensor_bypass       <= 1'b0;
      lamp_mask           <= lic_pkg::LAMP_MASK_RST;
      state               <= ST_OFF;
      return_state        <= ST_OFF;
      pending_on          <= 1'b0;
      pending_off         <= 1'b0;
      last_request        <= 1'b0;
      error_reported      <= 1'b0;
      error_code          <= lic_pkg::ERR_TIMEOUT;
      debounce_count      <= '{default: '0};
      lamp_status         <= '0;
      ignition_timer      <= '0;
      post_ignition_timer <= '0;
      drive               <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          lic_pkg::REG_IGN_TIMEOUT:  ign_timeout   <= cfg_data;
          lic_pkg::REG_POST_TIMEOUT: post_timeout  <= cfg_data;
          lic_pkg::REG_BYPASS:       sensor_bypass <= cfg_data[0];
          lic_pkg::REG_LAMP_MASK:    lamp_mask     <= cfg_data[1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        state               <= state_next;
        return_state        <= return_state_next;
        pending_on          <= pending_on_next;
        pending_off         <= pending_off_next;
        last_request        <= last_request_next;
        error_reported      <= error_reported_next;
        error_code          <= error_code_next;
        debounce_count      <= debounce_count_next;
        lamp_status         <= lamp_status_next;
        ignition_timer      <= ignition_timer_next;
        post_ignition_timer <= post_ignition_timer_next;
        drive               <= drive_next;
        out_valid           <= 1'b1;
        out_word            <= result_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ verif/tb_lamp_ignition_controller_top.sv @@
// Self-checking testbench for lamp_ignition_controller_top.
// Predicts every result word from its own copy of the controller state and checks it in order.
// Depends on lic_pkg and the design sources only.
module tb_lamp_ignition_controller_top;

  // Command codes the package leaves unnamed.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  // Controller state codes as shown on ctrl_state.
  localparam logic [2:0] ST_OFF        = 3'd0;
  localparam logic [2:0] ST_IGN        = 3'd1;
  localparam logic [2:0] ST_POST       = 3'd2;
  localparam logic [2:0] ST_SEND_ONOFF = 3'd3;
  localparam logic [2:0] ST_ON         = 3'd4;
  localparam logic [2:0] ST_SEND_ERR   = 3'd5;
  localparam logic [2:0] ST_SAFE       = 3'd6;

  localparam int DEB_MAX     = 4;
  localparam int STUCK_LIMIT = 1000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 116;
  localparam int HOLD_CYCLES = 60;

  // Tracks the controller pass by pass and keeps the result words still due.
  class ignition_pass_tracker;
    logic [15:0] ign_timeout, post_timeout;
    logic        bypass;
    logic [1:0]  lamp_mask;
    logic [2:0]  ctl_state, ret_state;
    logic        want_on, want_off, last_on, err_sent;
    logic [1:0]  err_code;
    logic [2:0]  dcount [2];
    logic        lit [2];
    logic        drive [2];
    logic [15:0] ign_timer, post_timer;
    lic_pkg::out_word_t due_results [$];
    int          bad_results;

    function new();
      reset_state();
      bad_results = 0;
    endfunction

    function void reset_state();
      ign_timeout = lic_pkg::IGN_TIMEOUT_RST;
      post_timeout = lic_pkg::POST_TIMEOUT_RST;
      bypass = 1'b0;
      lamp_mask = lic_pkg::LAMP_MASK_RST;
      ctl_state = ST_OFF;
      ret_state = ST_OFF;
      want_on = 0; want_off = 0; last_on = 0; err_sent = 0;
      err_code = lic_pkg::ERR_TIMEOUT;
      for (int i = 0; i < 2; i++) begin
        dcount[i] = '0;
        lit[i] = 1'b0;
        drive[i] = 1'b0;
      end
      ign_timer = '0;
      post_timer = '0;
    endfunction

    function void apply_reg(logic [lic_pkg::CFG_IDX_W-1:0] idx,
                            logic [lic_pkg::CFG_W-1:0] value);
      case (idx)
        lic_pkg::REG_IGN_TIMEOUT:  ign_timeout = value;
        lic_pkg::REG_POST_TIMEOUT: post_timeout = value;
        lic_pkg::REG_BYPASS:       bypass = value[0];
        lic_pkg::REG_LAMP_MASK:    lamp_mask = value[1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Effective statuses: bypass reads on, a lone enabled lamp speaks for both.
    function logic left_eff();
      if (bypass) return 1'b1;
      if (!lamp_mask[1] && lamp_mask[0]) return lit[1];
      return lit[0];
    endfunction

    function logic right_eff();
      if (bypass) return 1'b1;
      if (!lamp_mask[0] && lamp_mask[1]) return lit[0];
      return lit[1];
    endfunction

    function logic all_lit();
      if (lamp_mask[1] && !left_eff()) return 1'b0;
      if (lamp_mask[0] && !right_eff()) return 1'b0;
      return 1'b1;
    endfunction

    // One debounce sample with hysteresis; disabled lamps read dark.
    function void take_sample(logic lsens, logic rsens);
      logic sens [2];
      if (bypass) return;
      sens[0] = lamp_mask[1] & lsens;
      sens[1] = lamp_mask[0] & rsens;
      for (int i = 0; i < 2; i++) begin
        if (sens[i]) begin
          if (dcount[i] < DEB_MAX) dcount[i]++;
        end else if (dcount[i] != 0) begin
          dcount[i]--;
        end
        if (dcount[i] == DEB_MAX) lit[i] = 1'b1;
        else if (dcount[i] == 0) lit[i] = 1'b0;
      end
    endfunction

    function void set_lamps(logic on);
      dcount[0] = '0;
      dcount[1] = '0;
      if (lamp_mask[1]) drive[0] = on;
      if (lamp_mask[0]) drive[1] = on;
    endfunction

    // Runs one pass for an accepted input word and queues its result word.
    function void predict_pass(lic_pkg::in_word_t w);
      lic_pkg::out_word_t r;
      r = '0;
      if (w.command == lic_pkg::CMD_ON) begin
        last_on = 1; want_on = 1; want_off = 0; err_sent = 0;
      end else if (w.command == lic_pkg::CMD_OFF) begin
        last_on = 0; want_off = 1; want_on = 0;
      end
      if (w.sample_strobe) take_sample(w.left_sensor, w.right_sensor);
      if (w.second_tick) begin
        if (ign_timer != 0) ign_timer--;
        if (post_timer != 0) post_timer--;
      end

      case (ctl_state)
        ST_OFF: begin
          if (want_on) begin
            want_on = 0;
            if (!w.safety_active) begin
              set_lamps(1'b1);
              ign_timer = ign_timeout;
              ctl_state = ST_IGN;
            end else begin
              err_sent = 1;
              ret_state = ST_SAFE;
              err_code = lic_pkg::ERR_SAFETY;
              ctl_state = ST_SEND_ERR;
            end
          end else if (want_off) begin
            want_off = 0;
            set_lamps(1'b0);
            ret_state = ST_OFF;
            ctl_state = ST_SEND_ONOFF;
          end
        end
        ST_IGN: begin
          if (want_off) begin
            want_off = 0;
            set_lamps(1'b0);
            ctl_state = ST_SEND_ONOFF;
          end else begin
            take_sample(w.left_sensor, w.right_sensor);
            if (all_lit()) begin
              post_timer = post_timeout;
              ctl_state = ST_POST;
            end else if (ign_timer == 0) begin
              set_lamps(1'b0);
              ret_state = ST_OFF;
              err_code = lic_pkg::ERR_TIMEOUT;
              ctl_state = ST_SEND_ERR;
            end
          end
        end
        ST_POST: begin
          if (want_off) begin
            want_off = 0;
            set_lamps(1'b0);
            ctl_state = ST_SEND_ONOFF;
          end else begin
            take_sample(w.left_sensor, w.right_sensor);
            if (!all_lit()) begin
              ctl_state = ST_IGN;
            end else if (post_timer == 0) begin
              ret_state = ST_ON;
              ctl_state = ST_SEND_ONOFF;
            end
          end
        end
        ST_SEND_ONOFF: begin
          r.msg_valid = 1'b1;
          r.msg_kind = lic_pkg::MSG_ONOFF;
          r.msg_lamps_ok = all_lit();
          if (w.msg_accepted) ctl_state = ret_state;
        end
        ST_ON: begin
          if (want_off) begin
            want_off = 0;
            set_lamps(1'b0);
            ret_state = ST_OFF;
            ctl_state = ST_SEND_ONOFF;
          end else if (want_on) begin
            want_on = 0;
            ret_state = ST_ON;
            ctl_state = ST_SEND_ONOFF;
          end else if (!all_lit() && !err_sent) begin
            err_sent = 1;
            if (!w.safety_active) begin
              ret_state = ST_ON;
              err_code = lic_pkg::ERR_LAMP;
            end else begin
              ret_state = ST_SAFE;
              err_code = lic_pkg::ERR_SAFETY;
            end
            ctl_state = ST_SEND_ERR;
          end
        end
        ST_SEND_ERR: begin
          r.msg_valid = 1'b1;
          r.msg_kind = lic_pkg::MSG_ERROR;
          r.msg_error_code = err_code;
          r.msg_last_request = last_on;
          r.msg_left_status = left_eff();
          r.msg_right_status = right_eff();
          if (w.msg_accepted) ctl_state = ret_state;
        end
        ST_SAFE: begin
          if (w.safety_active) begin
            if (want_on) begin
              want_on = 0;
              ret_state = ST_SAFE;
              err_code = lic_pkg::ERR_SAFETY;
              ctl_state = ST_SEND_ERR;
            end else begin
              want_on = 0;
              want_off = 0;
            end
          end else begin
            want_on = 0;
            want_off = 0;
            set_lamps(1'b0);
            ctl_state = ST_OFF;
          end
        end
        default: ;
      endcase

      r.left_drive = drive[0];
      r.right_drive = drive[1];
      r.ctrl_state = ctl_state;
      due_results.push_back(r);
    endfunction

    // Compares an accepted result word with the oldest one due.
    function void check_pass_result(lic_pkg::out_word_t got);
      lic_pkg::out_word_t want;
      if (due_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) $display("unexpected result word: %p", got);
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        bad_results++;
        if (bad_results <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [lic_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lic_pkg::CFG_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  lic_pkg::in_word_t             in_word;
  logic                          out_valid;
  logic                          out_stall;
  lic_pkg::out_word_t            out_word;

  ignition_pass_tracker tracker;
  bit no_idle = 0;
  bit hold_go = 0;
  bit hold_done = 0;
  bit safety_lvl = 0;
  bit left_lvl = 0;
  bit right_lvl = 0;
  int stuck_cycles = 0;

  lamp_ignition_controller_top DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Observe both handshakes on the clock edge; results first, then the new word.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_pass_result(out_word);
      if (in_valid && !in_stall) tracker.predict_pass(in_word);
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Result side: random stalls, one long hold-off, and quiet stretches.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 11);
      end
    end
  end

  function automatic lic_pkg::in_word_t make_pass(logic [1:0] cmd, logic safety, logic lsens,
                                                  logic rsens, logic strobe, logic tick,
                                                  logic acc);
    lic_pkg::in_word_t w;
    w.command = cmd;
    w.safety_active = safety;
    w.left_sensor = lsens;
    w.right_sensor = rsens;
    w.sample_strobe = strobe;
    w.second_tick = tick;
    w.msg_accepted = acc;
    return w;
  endfunction

  // Random pass: held interlock and sensor levels with a little noise, so that
  // lamps mostly light and stay lit long enough for the sequence to progress.
  function automatic lic_pkg::in_word_t random_pass();
    lic_pkg::in_word_t w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) w.command = lic_pkg::CMD_ON;
    else if (pick < 11) w.command = lic_pkg::CMD_OFF;
    else if (pick < 13) w.command = CMD_RSVD;
    else w.command = CMD_NONE;
    if (safety_lvl) safety_lvl = ($urandom_range(99) >= 15);
    else safety_lvl = ($urandom_range(99) < 2);
    if (left_lvl) left_lvl = ($urandom_range(99) >= 3);
    else left_lvl = ($urandom_range(99) < 12);
    if (right_lvl) right_lvl = ($urandom_range(99) >= 3);
    else right_lvl = ($urandom_range(99) < 12);
    w.safety_active = safety_lvl;
    w.left_sensor = left_lvl ^ ($urandom_range(99) < 3);
    w.right_sensor = right_lvl ^ ($urandom_range(99) < 3);
    w.sample_strobe = ($urandom_range(99) < 60);
    w.second_tick = ($urandom_range(99) < 35);
    w.msg_accepted = ($urandom_range(99) < 55);
    return w;
  endfunction

  // One register write; the enable drops on the following cycle.
  task automatic load_reg(logic [lic_pkg::CFG_IDX_W-1:0] idx,
                          logic [lic_pkg::CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    tracker.apply_reg(idx, value);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one word, possibly after an idle gap, and wait until it is taken.
  task automatic send_pass(lic_pkg::in_word_t w);
    if (!no_idle && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every result word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    tracker = new();
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_word <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Short timeouts so the directed walk reaches the on state quickly.
    load_reg(lic_pkg::REG_IGN_TIMEOUT, 16'd3);
    load_reg(lic_pkg::REG_POST_TIMEOUT, 16'd1);
    load_reg(lic_pkg::REG_BYPASS, 16'd0);
    load_reg(lic_pkg::REG_LAMP_MASK, 16'd3);

    // Directed walk: reserved command, off notification with a retry, safety
    // refusal and release, full ignition to on, repeated on, lamp failure
    // through the debounce hysteresis, and off again.
    send_pass(make_pass(CMD_NONE,         0, 0, 0, 0, 0, 0));
    send_pass(make_pass(CMD_RSVD,         0, 1, 1, 1, 1, 1));
    send_pass(make_pass(lic_pkg::CMD_OFF, 0, 0, 0, 0, 0, 0));
    send_pass(make_pass(CMD_NONE,         0, 0, 0, 0, 0, 0));
    send_pass(make_pass(CMD_NONE,         0, 0, 0, 0, 0, 1));
    send_pass(make_pass(lic_pkg::CMD_ON,  1, 0, 0, 0, 0, 0));
    send_pass(make_pass(CMD_NONE,         1, 0, 0, 0, 0, 1));
    send_pass(make_pass(lic_pkg::CMD_ON,  1, 0, 0, 0, 0, 0));
    send_pass(make_pass(CMD_NONE,         1, 0, 0, 0, 0, 1));
    send_pass(make_pass(CMD_NONE,         0, 0, 0, 0, 0, 0));
    send_pass(make_pass(lic_pkg::CMD_ON,  0, 1, 1, 1, 0, 0));
    send_pass(make_pass(CMD_NONE,         0, 1, 1, 1, 0, 0));
    send_pass(make_pass(CMD_NONE,         0, 1, 1, 1, 0, 0));
    send_pass(make_pass(CMD_NONE,         0, 1, 1, 1, 1, 0));
    send_pass(make_pass(CMD_NONE,         0, 1, 1, 0, 0, 1));
    send_pass(make_pass(lic_pkg::CMD_ON,  0, 1, 1, 0, 0, 0));
    send_pass(make_pass(CMD_NONE,         0, 1, 1, 0, 0, 1));
    repeat (4) send_pass(make_pass(CMD_NONE, 0, 0, 0, 1, 1, 0));
    send_pass(make_pass(CMD_NONE,         0, 0, 0, 0, 0, 1));
    send_pass(make_pass(lic_pkg::CMD_OFF, 0, 0, 0, 0, 0, 0));
    send_pass(make_pass(CMD_NONE,         0, 0, 0, 0, 0, 1));
    send_pass(make_pass(lic_pkg::CMD_ON,  0, 0, 0, 0, 1, 0));
    drain();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          load_reg(lic_pkg::REG_IGN_TIMEOUT, 16'd0);
          load_reg(lic_pkg::REG_POST_TIMEOUT, 16'd0);
          load_reg(lic_pkg::REG_BYPASS, 16'd0);
          load_reg(lic_pkg::REG_LAMP_MASK, 16'd3);
        end
        1: begin
          load_reg(lic_pkg::REG_IGN_TIMEOUT, 16'hFFFF);
          load_reg(lic_pkg::REG_POST_TIMEOUT, 16'hFFFF);
          load_reg(lic_pkg::REG_BYPASS, 16'd1);
          load_reg(lic_pkg::REG_LAMP_MASK, 16'd0);
        end
        2, 3: begin
          load_reg(lic_pkg::REG_IGN_TIMEOUT, 16'($urandom_range(1, 8)));
          load_reg(lic_pkg::REG_POST_TIMEOUT, 16'($urandom_range(0, 6)));
          load_reg(lic_pkg::REG_BYPASS, 16'd0);
          load_reg(lic_pkg::REG_LAMP_MASK, (phase == 2) ? 16'd1 : 16'd2);
        end
        default: begin
          load_reg(lic_pkg::REG_IGN_TIMEOUT, 16'($urandom_range(0, 10)));
          load_reg(lic_pkg::REG_POST_TIMEOUT, 16'($urandom_range(0, 8)));
          load_reg(lic_pkg::REG_BYPASS, 16'($urandom_range(99) < 25));
          load_reg(lic_pkg::REG_LAMP_MASK, 16'($urandom_range(3)));
        end
      endcase
      // The long hold-off fills the block while words keep coming.
      if (phase == 2) hold_go = 1;
      no_idle = (phase == 3);
      repeat (PHASE_WORDS) send_pass(random_pass());
      drain();
    end

    if (tracker.bad_results == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ lamp_ignition_controller_top.f @@
design/lic_pkg.sv
design/lic_debounce.sv
design/lamp_ignition_controller_top.sv
verif/tb_lamp_ignition_controller_top.sv
